>>> design/rsam_pkg.sv
// Shared types and constants of the streaming regex matcher
`timescale 1ns / 1ps
`default_nettype none

package rsam_pkg;

  localparam int unsigned MAX_TOKENS_DEF = 32;
  localparam int unsigned SYM_W          = 21;
  localparam int unsigned SLOT_W         = 5;
  localparam int unsigned CNT_W          = 6;
  localparam int unsigned CFG_IDX_W      = 2;

  typedef enum logic [1:0] {
    CMD_TOKEN = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_END   = 2'd2
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_COUNT  = 2'd2;

  // closure and match carries handed from one position to the next
  typedef struct packed {
    logic cur;
    logic nxt;
    logic pre;
    logic adv;
  } link_t;

  // per-position values looked at by the accept select
  typedef struct packed {
    logic cur;
    logic cn;
    logic pre;
  } tap_t;

  typedef struct packed {
    logic step;
    logic clear;
    logic tok_wr;
  } cell_ctl_t;

  typedef struct packed {
    logic matched;
    logic final_res;
  } res_t;

endpackage

`default_nettype wire

>>> design/regex_star_anchor_matcher_unit.sv
// Top level of the streaming regex matcher: cell row, accept select, output stage
//
//  channel  | direction | handshake         | payload
//  in_      | input     | in_valid/in_stall | command, token_slot, symbol, repeat_flag
//  out_     | output    | out_valid/out_stall | matched, final_res
//  cfg_     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle while in_stall is low; each result is registered.
// The ripple of star closure through the cell row sets the cycle time.
// Reset clears the active positions, sticky flag, registers and output stage;
// tokens hold garbage until written. Results wait in an output register and a
// skid register; in_stall rises only when both are full. cfg_ready stays high.
`timescale 1ns / 1ps
`default_nettype none

module regex_star_anchor_matcher_unit #(
  parameter int unsigned MAX_TOKENS = rsam_pkg::MAX_TOKENS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       in_command,
  input  wire logic [rsam_pkg::SLOT_W-1:0]      in_token_slot,
  input  wire logic [rsam_pkg::SYM_W-1:0]       in_symbol,
  input  wire logic                             in_repeat_flag,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_matched,
  output logic                                  out_final_res,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rsam_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rsam_pkg::CNT_W-1:0]       cfg_data
);
  import rsam_pkg::*;

  logic             anc_start_r;
  logic             anc_end_r;
  logic [CNT_W-1:0] count_r;
  logic             found_r;
  logic             found_nxt;
  logic             at_start_r;
  logic             at_start_nxt;
  logic             end_active_r;
  logic             end_active_nxt;

  logic             accept;
  logic             is_char;
  logic             is_end;
  logic             gen;
  cell_ctl_t        ctl;
  logic             start_set;

  link_t            link_v [0:MAX_TOKENS];
  tap_t             taps   [0:MAX_TOKENS];
  logic [MAX_TOKENS:0] hit;
  logic [MAX_TOKENS:0] cur_vec;
  logic [MAX_TOKENS:0] cn_vec;
  logic [MAX_TOKENS:0] pre_vec;
  logic             acc0;
  logic             acc1;
  res_t             res;

  logic             out_valid_r;
  logic             out_valid_nxt;
  res_t             out_res_r;
  logic             skid_valid_r;
  logic             skid_valid_nxt;
  res_t             skid_res_r;
  logic             out_load;

  assign accept  = in_valid & ~in_stall;
  assign is_char = (in_command == CMD_CHAR);
  assign is_end  = (in_command == CMD_END);
  assign gen     = accept & (is_char | is_end);

  assign ctl.step   = accept & is_char;
  assign ctl.clear  = accept & is_end;
  assign ctl.tok_wr = accept & (in_command == CMD_TOKEN);

  assign start_set = ~anc_start_r | at_start_r;

  assign link_v[0].cur = start_set;
  assign link_v[0].nxt = 1'b0;
  assign link_v[0].pre = 1'b1;
  assign link_v[0].adv = 1'b0;

  for (genvar i = 0; i < MAX_TOKENS; i++) begin : g_cell
    rsam_cell #(
      .IDX (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .sym    (in_symbol),
      .rep    (in_repeat_flag),
      .slot   (in_token_slot),
      .cnt    (count_r),
      .link_i (link_v[i]),
      .link_o (link_v[i+1]),
      .tap_o  (taps[i])
    );
    assign hit[i] = (32'(count_r) == 32'(i));
  end

  assign taps[MAX_TOKENS].cur = end_active_r | link_v[MAX_TOKENS].cur;
  assign taps[MAX_TOKENS].cn  = link_v[MAX_TOKENS].adv | link_v[MAX_TOKENS].nxt;
  assign taps[MAX_TOKENS].pre = link_v[MAX_TOKENS].pre;
  assign hit[MAX_TOKENS]      = (32'(count_r) >= MAX_TOKENS);

  for (genvar i = 0; i <= MAX_TOKENS; i++) begin : g_tap
    assign cur_vec[i] = taps[i].cur;
    assign cn_vec[i]  = taps[i].cn;
    assign pre_vec[i] = taps[i].pre;
  end

  assign acc0 = |(cur_vec & hit);
  assign acc1 = (|(cn_vec & hit)) | (~anc_start_r & (|(pre_vec & hit)));

  always_comb begin
    res.final_res = is_end;
    if (is_end) begin
      res.matched = anc_end_r ? acc0 : (found_r | acc0);
    end else begin
      res.matched = anc_end_r ? acc1 : (found_r | acc0 | acc1);
    end
  end

  always_comb begin
    found_nxt      = found_r;
    at_start_nxt   = at_start_r;
    end_active_nxt = end_active_r;
    if (ctl.clear) begin
      found_nxt      = 1'b0;
      at_start_nxt   = 1'b1;
      end_active_nxt = 1'b0;
    end else if (ctl.step) begin
      found_nxt      = found_r | acc0 | acc1;
      at_start_nxt   = 1'b0;
      end_active_nxt = taps[MAX_TOKENS].cn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r      <= 1'b0;
      at_start_r   <= 1'b1;
      end_active_r <= 1'b0;
    end else begin
      found_r      <= found_nxt;
      at_start_r   <= at_start_nxt;
      end_active_r <= end_active_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anc_start_r <= 1'b0;
      anc_end_r   <= 1'b0;
      count_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ANCHOR_START: anc_start_r <= cfg_data[0];
        CFG_ANCHOR_END:   anc_end_r   <= cfg_data[0];
        CFG_TOKEN_COUNT:  count_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register plus skid register
  assign out_load       = ~out_valid_r | ~out_stall;
  assign out_valid_nxt  = out_load ? (skid_valid_r | gen) : 1'b1;
  assign skid_valid_nxt = skid_valid_r ? ~out_load : (gen & ~out_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= skid_valid_r ? skid_res_r : res;
    end
    if (gen && !out_load) begin
      skid_res_r <= res;
    end
  end

  assign in_stall      = skid_valid_r;
  assign out_valid     = out_valid_r;
  assign out_matched   = out_res_r.matched;
  assign out_final_res = out_res_r.final_res;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_end) |=> (at_start_r && !found_r && !end_active_r))
    else $error("end of text did not clear text state");

  a_char_leaves_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_char) |=> !at_start_r)
    else $error("text start flag survived a character");

endmodule

`default_nettype wire

>>> design/rsam_cell.sv
// One expression position: token storage, active bit and closure carry
`timescale 1ns / 1ps
`default_nettype none

module rsam_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rsam_pkg::cell_ctl_t          ctl,
  input  wire logic [rsam_pkg::SYM_W-1:0]   sym,
  input  wire logic                         rep,
  input  wire logic [rsam_pkg::SLOT_W-1:0]  slot,
  input  wire logic [rsam_pkg::CNT_W-1:0]   cnt,
  input  wire rsam_pkg::link_t              link_i,
  output rsam_pkg::link_t                   link_o,
  output rsam_pkg::tap_t                    tap_o
);
  import rsam_pkg::*;

  logic [SYM_W-1:0] code_r;
  logic             rep_r;
  logic             active_r;
  logic             active_nxt;
  logic             live;
  logic             eq;
  logic             cur;
  logic             raw;
  logic             cn;

  assign live = (32'(cnt) > IDX);
  assign eq   = (code_r == sym);
  assign cur  = active_r | link_i.cur;
  assign raw  = (cur & eq & rep_r & live) | link_i.adv;
  assign cn   = raw | link_i.nxt;

  assign link_o.cur = cur & rep_r & live;
  assign link_o.nxt = cn & rep_r & live;
  assign link_o.pre = link_i.pre & rep_r & live;
  assign link_o.adv = cur & eq & ~rep_r & live;

  assign tap_o.cur = cur;
  assign tap_o.cn  = cn;
  assign tap_o.pre = link_i.pre;

  always_comb begin
    active_nxt = active_r;
    if (ctl.clear) begin
      active_nxt = 1'b0;
    end else if (ctl.step) begin
      active_nxt = cn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tok_wr && (32'(slot) == IDX)) begin
      code_r <= sym;
      rep_r  <= rep;
    end
  end

endmodule

`default_nettype wire
